FILE: rtl/bwsd_pkg.sv
// ----------------------------------------------------------------------------
// bwsd_pkg
// Types and constants shared by the back-EMF window stall detector.
// ----------------------------------------------------------------------------
package bwsd_pkg;

  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned THRESH_W      = 13;
  localparam int unsigned AXIS_W        = 2;
  // Only three axes carry a sample field in the input transaction.
  localparam int unsigned SAMPLE_FIELDS = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd100;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [SAMPLE_W-1:0] sample_z;
    logic [AXIS_W-1:0]   axis;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_to_peak;
    logic                stalled;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;    // write one row of samples and advance the write slot
    logic load;     // latch the queried axis and reset the extremes
    logic scan_rd;  // read the next window slot
    logic finish;   // register the result and pulse the strobe
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_rd;  // the read index points at the final window slot
  } sts_t;

endpackage

FILE: rtl/bwsd_ctrl.sv
// ----------------------------------------------------------------------------
// bwsd_ctrl
// Controller: accepts transactions and sequences the window scan.
// ----------------------------------------------------------------------------
module bwsd_ctrl
  import bwsd_pkg::*;
#(
  parameter int unsigned AXES = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;
  logic   axis_ok;

  assign busy    = busy_q;
  assign accept  = start && !busy_q;
  assign axis_ok = (int'(in_i.axis) < int'(SAMPLE_FIELDS)) && (int'(in_i.axis) < int'(AXES));

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.store = accept && (in_i.action == ACT_STORE);
        cmd_o.load  = accept && (in_i.action == ACT_QUERY) && axis_ok;
      end
      ST_SCAN: cmd_o.scan_rd = 1'b1;
      ST_WAIT: ;
      ST_FIN:  cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_SCAN;
            busy_q  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts_i.last_rd) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: state_q <= ST_FIN;
        ST_FIN: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/bwsd_dp.sv
// ----------------------------------------------------------------------------
// bwsd_dp
// Datapath: sample ring memory, row valid bits, write slot, min/max scan.
// ----------------------------------------------------------------------------
module bwsd_dp
  import bwsd_pkg::*;
#(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned AXES   = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_t                 in_i,
  input  cmd_t                cmd_i,
  input  logic [THRESH_W-1:0] thresh_i,
  output sts_t                sts_o,
  output logic                done_o,
  output out_t                res_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned ROW_W  = AXES * SAMPLE_W;

  // One row holds one sample of every axis; a store writes a whole row.
  logic [ROW_W-1:0]    mem_q [WINDOW];
  logic [WINDOW-1:0]   row_vld_q;
  logic [SLOT_W-1:0]   wr_slot_q;
  logic [SLOT_W-1:0]   rd_idx_q;
  logic [AXIS_W-1:0]   axis_q;
  logic [ROW_W-1:0]    rdata_q;
  logic                rvld_q;
  logic                rd_pend_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic [SAMPLE_W-1:0] lo_q;
  logic                done_q;
  out_t                res_q;

  logic [ROW_W-1:0]    wr_row;
  logic [SAMPLE_W-1:0] lane;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] ptp;

  always_comb begin
    wr_row = '0;
    for (int a = 0; a < int'(AXES); a++) begin
      if (a == 0) wr_row[a*SAMPLE_W +: SAMPLE_W] = in_i.sample_x;
      if (a == 1) wr_row[a*SAMPLE_W +: SAMPLE_W] = in_i.sample_y;
      if (a == 2) wr_row[a*SAMPLE_W +: SAMPLE_W] = in_i.sample_z;
    end
  end

  always_comb begin
    lane = '0;
    for (int a = 0; a < int'(AXES); a++) begin
      if (int'(axis_q) == a) lane = rdata_q[a*SAMPLE_W +: SAMPLE_W];
    end
  end

  // A row never written since reset reads as zero.
  assign smp     = rvld_q ? lane : '0;
  assign ptp     = hi_q - lo_q;
  assign sts_o.last_rd = (rd_idx_q == SLOT_W'(WINDOW - 1));
  assign done_o  = done_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[wr_slot_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      wr_slot_q <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      rvld_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_rd;
      rvld_q    <= row_vld_q[rd_idx_q];
      done_q    <= cmd_i.finish;
      if (cmd_i.store) begin
        row_vld_q[wr_slot_q] <= 1'b1;
        if (wr_slot_q == SLOT_W'(WINDOW - 1)) begin
          wr_slot_q <= '0;
        end else begin
          wr_slot_q <= wr_slot_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_rd && !sts_o.last_rd) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      axis_q <= in_i.axis;
      hi_q   <= '0;
      lo_q   <= SAMPLE_MAX;
    end else if (rd_pend_q) begin
      if (smp > hi_q) hi_q <= smp;
      if (smp < lo_q) lo_q <= smp;
    end
    if (cmd_i.finish) begin
      res_q.peak_to_peak <= ptp;
      res_q.stalled      <= ({1'b0, ptp} < thresh_i);
    end
  end

endmodule

FILE: rtl/bemf_window_stall_detector.sv
// ----------------------------------------------------------------------------
// bemf_window_stall_detector
// Windowed peak-to-peak back-EMF stall detector for several motor axes.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Transfer rule
//  -------   -------------------------------  ---------  ----------------------
//  command   start, busy, in_i                in         start && !busy
//  result    done_o, res_o                    out        done_o, one cycle
//  config    cfg_valid_i, cfg_ready_o,        in         cfg_valid_i && ready
//            cfg_data_i
//
//  A store transaction leaves busy low, and the next transaction may follow
//  right away. A query transaction holds busy high while the single read port
//  of the sample memory walks the window one row per cycle, and the result
//  strobe comes in the first cycle in which busy is low again.
//  A query naming a nonexistent axis is accepted and produces no result.
//  Reset clears the row valid bits at once, so no clearing pass is needed;
//  an unwritten row reads as zero. The receiver cannot stall the result.
//
// ----------------------------------------------------------------------------
module bemf_window_stall_detector
  import bwsd_pkg::*;
#(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned AXES   = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  in_t                 in_i,
  // Result channel.
  output logic                done_o,
  output out_t                res_o,
  // Configuration channel for the stall threshold.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [THRESH_W-1:0] cfg_data_i
);

  cmd_t                cmd;
  sts_t                sts;
  logic [THRESH_W-1:0] thresh_q;

  // The threshold register is always ready; software must write it only while
  // the block is idle, and the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  // The controller decodes each transaction and steps the scan; the datapath
  // owns the ring memory and the running maximum and minimum.
  bwsd_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bwsd_dp #(
    .WINDOW (WINDOW),
    .AXES   (AXES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .thresh_i (thresh_q),
    .sts_o    (sts),
    .done_o   (done_o),
    .res_o    (res_o)
  );

  // A result strobe always lands in a cycle where a new command may be
  // accepted.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A store never leaves the block busy.
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.action == ACT_STORE)) |=> !busy)
    else $error("store left the block busy");

  // A valid query starts a scan.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> busy)
    else $error("query did not raise busy");

  // The stall flag agrees with the delivered peak-to-peak value.
  a_stall_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.stalled == ({1'b0, res_o.peak_to_peak} < thresh_q)))
    else $error("stall flag disagrees with threshold");

endmodule
